// ----- design/tlut_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_pkg
// Shared types and constants of the trilinear 3D lookup table sampler.
// ----------------------------------------------------------------------------
package tlut_pkg;

  // Default sizes of the lattice and of the coordinate fraction.
  localparam int MAX_SIDE_DEF  = 33;
  localparam int FRAC_BITS_DEF = 16;

  // Channel width and the side value after reset.
  localparam int         CH_W       = 16;
  localparam logic [5:0] SIDE_RESET = 6'd33;

  // Configuration register indexes.
  localparam logic CFG_IDX_LUT_SIDE = 1'b0;

  // Item operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One lattice entry: three channels.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } entry_t;

endpackage

// ----- design/tlut_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_axis
// Splits one coordinate into a lower corner index and a fraction, registered.
// ----------------------------------------------------------------------------
module tlut_axis #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 6
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   coord,
  input  logic [SW-1:0]        side,
  output logic [SW-1:0]        idx_r,
  output logic [FRAC_BITS:0]   frac_r
);
  import tlut_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]      sat;
  logic [FRAC_BITS+SW:0]   prod;
  logic [SW:0]             idx_raw;
  logic [SW:0]             top;
  logic [SW-1:0]           idx_nxt;
  logic [FRAC_BITS:0]      frac_nxt;

  // Saturate, scale by side-1 and clamp the corner at the top edge.
  always_comb begin
    sat      = (coord > ONE) ? ONE : coord;
    prod     = (FRAC_BITS+SW+1)'(sat) * (FRAC_BITS+SW+1)'(side - SW'(1));
    idx_raw  = prod[FRAC_BITS+SW:FRAC_BITS];
    top      = (SW+1)'(side) - (SW+1)'(2);
    idx_nxt  = idx_raw[SW-1:0];
    frac_nxt = {1'b0, prod[FRAC_BITS-1:0]};
    if (idx_raw > top) begin
      idx_nxt  = top[SW-1:0];
      frac_nxt = ONE;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    frac_r <= frac_nxt;
  end

endmodule

// ----- design/tlut_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_bank
// One copy of the lattice store: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module tlut_bank #(
  parameter int DEPTH = 35937,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tlut_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output tlut_pkg::entry_t rdata_r
);
  import tlut_pkg::*;

  entry_t mem [DEPTH];

  // A read in the same cycle as a write to that entry returns the old entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- design/tlut_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlut_blend
// Three-stage trilinear blend of eight corners for one channel.
// ----------------------------------------------------------------------------
module tlut_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic [tlut_pkg::CH_W-1:0]     corner [8],
  input  logic [FRAC_BITS:0]            fx,
  input  logic [FRAC_BITS:0]            fy,
  input  logic [FRAC_BITS:0]            fz,
  output logic [tlut_pkg::CH_W-1:0]     res_r
);
  import tlut_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = CH_W + F;
  localparam int XW  = CH_W + F + 2;
  localparam int YW  = VW + F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [YW-1:0] HALF1 = YW'(1) << (F - 1);
  localparam logic [YW-1:0] HALF2 = YW'(1) << (2 * F - 1);

  logic [VW-1:0] vx_r [4];
  logic [VW-1:0] vy_r [2];
  logic [F:0]    fy1_r, fz1_r, fz2_r;
  logic [VW-1:0] vx_nxt [4];
  logic [VW-1:0] vy_nxt [2];
  logic [YW-1:0] sy [2];
  logic [YW-1:0] sz;
  logic [XW-1:0] sx;
  logic [F:0]    gx, gy, gz;

  // Blend along red, then green with rounding, then blue to an integer.
  always_comb begin
    gx = ONE - fx;
    gy = ONE - fy1_r;
    gz = ONE - fz2_r;
    for (int k = 0; k < 4; k++) begin
      sx = XW'(corner[2*k]) * XW'(gx) + XW'(corner[2*k+1]) * XW'(fx);
      vx_nxt[k] = sx[VW-1:0];
    end
    for (int k = 0; k < 2; k++) begin
      sy[k] = YW'(vx_r[2*k]) * YW'(gy) + YW'(vx_r[2*k+1]) * YW'(fy1_r) + HALF1;
      vy_nxt[k] = sy[k][VW+F-1:F];
    end
    sz = YW'(vy_r[0]) * YW'(gz) + YW'(vy_r[1]) * YW'(fz2_r) + HALF2;
  end

  always_ff @(posedge clk) begin
    vx_r  <= vx_nxt;
    fy1_r <= fy;
    fz1_r <= fz;
    vy_r  <= vy_nxt;
    fz2_r <= fz1_r;
    res_r <= sz[2*F+CH_W-1:2*F];
  end

endmodule

// ----- design/trilinear_3d_lut_sampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_3d_lut_sampler_core
// Trilinear 3D colour lookup table: lattice writes and pipelined samples.
// ----------------------------------------------------------------------------
// A sample passes the input, axis, address, store read and blend registers to the output.
// Throughput: one item per cycle; busy stays low, as eight copies of the
// store give all eight corners in a single read.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset clears the pipeline and sets lut_side to 33; the store is undefined.
module trilinear_3d_lut_sampler_core #(
  parameter int MAX_SIDE  = tlut_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = tlut_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [15:0]                in_entry_index,
  input  logic [tlut_pkg::CH_W-1:0]  in_entry_red,
  input  logic [tlut_pkg::CH_W-1:0]  in_entry_green,
  input  logic [tlut_pkg::CH_W-1:0]  in_entry_blue,
  input  logic [FRAC_BITS:0]         in_coord_red,
  input  logic [FRAC_BITS:0]         in_coord_green,
  input  logic [FRAC_BITS:0]         in_coord_blue,
  output logic                       out_valid,
  output logic [tlut_pkg::CH_W-1:0]  out_red,
  output logic [tlut_pkg::CH_W-1:0]  out_green,
  output logic [tlut_pkg::CH_W-1:0]  out_blue,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tlut_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 3 * SW;

  // Configuration and derived side values.
  logic [5:0]      lut_side_r;
  logic [SW-1:0]   side_r;
  logic [2*SW-1:0] ss_r;
  logic [AW-1:0]   off_r [8];
  logic [7:0]      side_ext;

  // Pipeline registers.
  logic            vld1_r, vld2_r, vld3_r, vld4_r;
  logic            op1_r, op2_r, op3_r, op4_r;
  logic [15:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  entry_t          dat1_r, dat2_r, dat3_r, dat4_r;
  logic [FRAC_BITS:0] crd_r [3];
  logic [SW-1:0]   ci [3];
  logic [FRAC_BITS:0] cf [3];
  logic [2*SW-1:0] zy3_r;
  logic [SW-1:0]   ix3_r;
  logic [FRAC_BITS:0] f3_r [3];
  logic [FRAC_BITS:0] f4_r [3];
  logic [FRAC_BITS:0] f5_r [3];
  logic [AW-1:0]   base4_r;
  logic            smp5_r, smp6_r, smp7_r, out_valid_r;
  logic [PW-1:0]   zy_prod, base_prod;
  logic            mem_we;
  entry_t          corner_r [8];
  logic [CH_W-1:0] ch_red [8];
  logic [CH_W-1:0] ch_green [8];
  logic [CH_W-1:0] ch_blue [8];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register write and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_side_r <= SIDE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_LUT_SIDE) begin
      lut_side_r <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_LUT_SIDE) ? {26'd0, lut_side_r} : 32'd0;

  // Effective side, its square and the eight corner offsets.
  always_comb begin
    side_ext = {2'b00, lut_side_r};
    if (side_ext < 8'd2) begin
      side_ext = 8'd2;
    end else if (side_ext > 8'(MAX_SIDE)) begin
      side_ext = 8'(MAX_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_ext[SW-1:0];
    ss_r   <= (2*SW)'(side_r) * (2*SW)'(side_r);
    for (int k = 0; k < 8; k++) begin
      off_r[k] <= AW'(k & 1) + (((k >> 1) & 1) != 0 ? AW'(side_r) : AW'(0))
                + (((k >> 2) & 1) != 0 ? AW'(ss_r) : AW'(0));
    end
  end

  // Valid chain of the front stages, then the sample chain up to out_valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      smp5_r <= 1'b0;
      smp6_r <= 1'b0;
      smp7_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r <= start && !busy;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      smp5_r <= vld4_r && op4_r == OP_SAMPLE;
      smp6_r <= smp5_r;
      smp7_r <= smp6_r;
      out_valid_r <= smp7_r;
    end
  end

  // Payload of the front stages; writes travel along to meet the read stage.
  always_ff @(posedge clk) begin
    op1_r    <= in_op;
    idx1_r   <= in_entry_index;
    dat1_r   <= '{red: in_entry_red, green: in_entry_green, blue: in_entry_blue};
    crd_r[0] <= in_coord_red;
    crd_r[1] <= in_coord_green;
    crd_r[2] <= in_coord_blue;
    op2_r  <= op1_r;
    idx2_r <= idx1_r;
    dat2_r <= dat1_r;
    op3_r  <= op2_r;
    idx3_r <= idx2_r;
    dat3_r <= dat2_r;
    op4_r  <= op3_r;
    idx4_r <= idx3_r;
    dat4_r <= dat3_r;
    zy3_r  <= zy_prod[2*SW-1:0];
    ix3_r  <= ci[0];
    f3_r   <= cf;
    base4_r <= base_prod[AW-1:0];
    f4_r   <= f3_r;
    f5_r   <= f4_r;
  end

  // Corner index and fraction of each axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    tlut_axis #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_axis (
      .clk    (clk),
      .coord  (crd_r[a]),
      .side   (side_r),
      .idx_r  (ci[a]),
      .frac_r (cf[a])
    );
  end

  // Linear address of the lower corner, one multiply per stage.
  assign zy_prod   = PW'(ci[2]) * PW'(side_r) + PW'(ci[1]);
  assign base_prod = PW'(zy3_r) * PW'(side_r) + PW'(ix3_r);

  assign mem_we = vld4_r && op4_r == OP_WRITE && 32'(idx4_r) < 32'(DEPTH);

  // Eight copies of the store, one for each corner of the cube.
  for (genvar k = 0; k < 8; k++) begin : g_bank
    tlut_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
      .clk     (clk),
      .we      (mem_we),
      .waddr   (AW'(idx4_r)),
      .wdata   (dat4_r),
      .raddr   (base4_r + off_r[k]),
      .rdata_r (corner_r[k])
    );
    assign ch_red[k]   = corner_r[k].red;
    assign ch_green[k] = corner_r[k].green;
    assign ch_blue[k]  = corner_r[k].blue;
  end

  // Per-channel blend.
  tlut_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_red (
    .clk(clk), .corner(ch_red), .fx(f5_r[0]), .fy(f5_r[1]), .fz(f5_r[2]), .res_r(out_red)
  );
  tlut_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_green (
    .clk(clk), .corner(ch_green), .fx(f5_r[0]), .fy(f5_r[1]), .fz(f5_r[2]),
    .res_r(out_green)
  );
  tlut_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_blue (
    .clk(clk), .corner(ch_blue), .fx(f5_r[0]), .fy(f5_r[1]), .fz(f5_r[2]), .res_r(out_blue)
  );

  assign out_valid = out_valid_r;

  // A sample always yields a strobe at the output; a write never does.
  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_SAMPLE) |-> ##8 out_valid)
    else $error("sample item produced no result");
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_WRITE) |-> ##8 !out_valid)
    else $error("write item produced a result");
  a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (side_r >= SW'(2) && side_r <= SW'(MAX_SIDE)))
    else $error("effective side out of range");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trilinear 3D lookup table sampler core.
// Lattice writes and sample items are fed through the start/busy handshake
// with random gaps. Every sample is predicted by a fixed-point blend over a
// local copy of the lattice and compared with the strobed result. Before a
// sample is queued, every corner it reads is written first. The side
// register is rewritten over the APB-style port between drained phases.
// ----------------------------------------------------------------------------
module tb;
  import tlut_pkg::*;

  localparam int DEPTH     = MAX_SIDE_DEF * MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int ONE       = 1 << FRAC_BITS_DEF;
  localparam int STALL_MAX = 5000;
  localparam logic [2:0] ADDR_LUT_SIDE = {1'b0, CFG_IDX_LUT_SIDE, 1'b0} << 1;
  localparam logic [2:0] ADDR_UNUSED   = 3'd4;

  typedef struct {
    logic        op;
    logic [15:0] index;
    entry_t      value;
    logic [16:0] cr, cg, cb;
  } lut_item_t;

  logic clk, rst_n, start, busy;
  logic in_op;
  logic [15:0] in_entry_index;
  logic [CH_W-1:0] in_entry_red, in_entry_green, in_entry_blue;
  logic [16:0] in_coord_red, in_coord_green, in_coord_blue;
  logic out_valid;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  trilinear_3d_lut_sampler_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_entry_index(in_entry_index),
    .in_entry_red(in_entry_red), .in_entry_green(in_entry_green),
    .in_entry_blue(in_entry_blue), .in_coord_red(in_coord_red),
    .in_coord_green(in_coord_green), .in_coord_blue(in_coord_blue),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Pending items, predicted colours and the local copies of the block state.
  lut_item_t pending_items[$];
  entry_t    colour_expected[$];
  entry_t    lattice_model[DEPTH];
  bit        queued_written[DEPTH];
  logic [5:0] side_model;
  lut_item_t on_port;
  int        gap_left;
  bit        quiet;
  int        mismatches;
  int        stall_cycles;

  // Clock.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int eff_side(input logic [5:0] s);
    if (s < 2) return 2;
    if (s > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return s;
  endfunction

  // Splits one coordinate into a lower corner and a blend fraction.
  function automatic void axis_split(input logic [16:0] c, input int s,
                                     output int idx, output longint unsigned frac);
    longint unsigned p;
    p = (c > ONE ? ONE : c) * (s - 1);
    idx  = int'(p >> FRAC_BITS_DEF);
    frac = p & (ONE - 1);
    if (idx > s - 2) begin
      idx  = s - 2;
      frac = ONE;
    end
  endfunction

  function automatic longint unsigned corner(input int s, input int x, input int y,
                                             input int z, input int ch);
    int a;
    a = (z * s + y) * s + x;
    if (a >= DEPTH) return 0;
    case (ch)
      0: return lattice_model[a].red;
      1: return lattice_model[a].green;
      default: return lattice_model[a].blue;
    endcase
  endfunction

  // Trilinear blend: red, then green with rounding, then blue with rounding.
  function automatic entry_t blend_colour(input lut_item_t it);
    int s, x, y, z, ch;
    longint unsigned fx, fy, fz, gx, gy, gz, v00, v10, v01, v11, v0, v1, v;
    logic [CH_W-1:0] res[3];
    entry_t e;
    s = eff_side(side_model);
    axis_split(it.cr, s, x, fx);
    axis_split(it.cg, s, y, fy);
    axis_split(it.cb, s, z, fz);
    gx = ONE - fx; gy = ONE - fy; gz = ONE - fz;
    for (ch = 0; ch < 3; ch++) begin
      v00 = corner(s, x, y, z, ch) * gx + corner(s, x + 1, y, z, ch) * fx;
      v10 = corner(s, x, y + 1, z, ch) * gx + corner(s, x + 1, y + 1, z, ch) * fx;
      v01 = corner(s, x, y, z + 1, ch) * gx + corner(s, x + 1, y, z + 1, ch) * fx;
      v11 = corner(s, x, y + 1, z + 1, ch) * gx
          + corner(s, x + 1, y + 1, z + 1, ch) * fx;
      v0 = (v00 * gy + v10 * fy + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
      v1 = (v01 * gy + v11 * fy + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
      v  = (v0 * gz + v1 * fz + (64'd1 << (2 * FRAC_BITS_DEF - 1)))
           >> (2 * FRAC_BITS_DEF);
      if (v > 16'hFFFF) v = 16'hFFFF;
      res[ch] = v[15:0];
    end
    e.red = res[0]; e.green = res[1]; e.blue = res[2];
    return e;
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Coordinates lean on the edges and on values above one.
  function automatic logic [16:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'(ONE);
      2: return 17'($urandom_range(ONE + 1, 17'h1FFFF));
      3: return 17'($urandom_range(ONE - 16, ONE - 1));
      default: return 17'($urandom_range(0, ONE));
    endcase
  endfunction

  task automatic queue_write(input int idx, input entry_t v);
    lut_item_t it;
    it.op = OP_WRITE; it.index = 16'(idx); it.value = v;
    it.cr = 17'($urandom); it.cg = 17'($urandom); it.cb = 17'($urandom);
    pending_items.push_back(it);
    if (idx < DEPTH) queued_written[idx] = 1'b1;
  endtask

  // Queues one sample, preceded by writes of any corner not yet written.
  task automatic queue_sample(input logic [16:0] cr, input logic [16:0] cg,
                              input logic [16:0] cb);
    lut_item_t it;
    entry_t v;
    int s, x, y, z, a, dx, dy, dz;
    longint unsigned f;
    s = eff_side(side_model);
    axis_split(cr, s, x, f);
    axis_split(cg, s, y, f);
    axis_split(cb, s, z, f);
    for (dz = 0; dz < 2; dz++)
      for (dy = 0; dy < 2; dy++)
        for (dx = 0; dx < 2; dx++) begin
          a = ((z + dz) * s + y + dy) * s + x + dx;
          if (!queued_written[a]) begin
            v.red = rand_channel(); v.green = rand_channel(); v.blue = rand_channel();
            queue_write(a, v);
          end
        end
    it.op = OP_SAMPLE; it.index = 16'($urandom); it.value = {16'($urandom), $urandom};
    it.cr = cr; it.cg = cg; it.cb = cb;
    pending_items.push_back(it);
  endtask

  // Driver: predicts each accepted item, then presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start          <= 1'b0;
      in_op          <= OP_WRITE;
      in_entry_index <= '0;
      in_entry_red   <= '0;
      in_entry_green <= '0;
      in_entry_blue  <= '0;
      in_coord_red   <= '0;
      in_coord_green <= '0;
      in_coord_blue  <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        if (on_port.op == OP_SAMPLE) begin
          colour_expected.push_back(blend_colour(on_port));
        end else if (on_port.index < DEPTH) begin
          lattice_model[on_port.index] = on_port.value;
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_port = pending_items.pop_front();
          start          <= 1'b1;
          in_op          <= on_port.op;
          in_entry_index <= on_port.index;
          in_entry_red   <= on_port.value.red;
          in_entry_green <= on_port.value.green;
          in_entry_blue  <= on_port.value.blue;
          in_coord_red   <= on_port.cr;
          in_coord_green <= on_port.cg;
          in_coord_blue  <= on_port.cb;
          if (!quiet && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    entry_t want;
    if (rst_n && out_valid) begin
      if (colour_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h %h %h", out_red, out_green,
                                       out_blue);
      end else begin
        want = colour_expected.pop_front();
        if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Colour mismatch: expected %h %h %h, got %h %h %h", want.red,
                     want.green, want.blue, out_red, out_green, out_blue);
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("trilinear_3d_lut_sampler_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_LUT_SIDE) side_model = data[5:0];
  endtask

  // Waits until every item has gone in and every result has come out.
  task automatic drain();
    wait (pending_items.size() == 0 && !start && colour_expected.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  // Stimulus: directed edges at the reset side, then random phases per side.
  initial begin
    logic [5:0] sides[9] = '{6'd2, 6'd0, 6'd1, 6'd5, 6'd17, 6'd63, 6'd3, 6'd33, 6'd9};
    entry_t v;
    int p, n;
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    quiet = 1'b0; side_model = SIDE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme entries, ignored addresses, edges and coordinates above one.
    v = '1; queue_write(0, v);
    v = '0; queue_write(DEPTH - 1, v);
    v = {16'h1234, 16'h5678, 16'h9ABC};
    queue_write(DEPTH, v);
    queue_write(16'hFFFF, v);
    queue_sample(17'd0, 17'd0, 17'd0);
    queue_sample(17'(ONE), 17'(ONE), 17'(ONE));
    queue_sample(17'h1FFFF, 17'(ONE + 1), 17'(ONE / 2));
    queue_sample(17'd1, 17'(ONE - 1), 17'd0);
    queue_sample(17'(ONE - 1), 17'(ONE - 1), 17'(ONE - 1));
    drain();
    cfg_write(ADDR_UNUSED, 32'hFFFF_FFFF);

    for (p = 0; p < 9; p++) begin
      if (p == 8) quiet = 1'b1;
      drain();
      cfg_write(ADDR_LUT_SIDE, {26'($urandom), sides[p]});
      n = pending_items.size();
      while (pending_items.size() - n < 190) begin
        if ($urandom_range(0, 19) == 0) begin
          v = {16'($urandom), $urandom};
          queue_write($urandom_range(DEPTH, 16'hFFFF), v);
        end else begin
          queue_sample(rand_coord(), rand_coord(), rand_coord());
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && colour_expected.size() == 0) begin
      $display("trilinear_3d_lut_sampler_core test passed");
    end else begin
      $display("trilinear_3d_lut_sampler_core test failed");
    end
    $finish;
  end

endmodule
